// ===== rtl/qtge_pkg.sv =====
// Shared types, constants and mod-3 helpers for the qutrit tableau gate engine.
// No dependencies; imported by the controller, the datapath and the top level.
package qtge_pkg;

    // Field widths
    localparam int OP_W  = 3;
    localparam int QI_W  = 4;
    localparam int IDX_W = 5;
    localparam int TRIT_W = 2;
    localparam int NQ_W  = 5;

    // Compare width for qutrit counts and tableau dimension (up to 64)
    localparam int CMP_W = 7;

    localparam int MAX_QUTRITS_DEF = 16;
    localparam logic [NQ_W-1:0] NQ_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_HADAMARD    = 3'd0,
        OP_PHASE       = 3'd1,
        OP_CSUM        = 3'd2,
        OP_WRITE_TRIT  = 3'd3,
        OP_WRITE_PHASE = 3'd4,
        OP_READ_TRIT   = 3'd5,
        OP_READ_PHASE  = 3'd6,
        OP_MEASURE     = 3'd7
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the input item
        logic rd_en;     // read one tableau row
        logic sweep;     // row address from the sweep counter
        logic wb;        // write the read row back, modified
        logic phase_wr;  // write phase trit of the item row
        logic cnt_clr;
        logic cnt_inc;
        logic emit;      // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic bad;       // index or value out of range, or CSUM target equals control
        logic out_free;  // result register can take a result
        logic cnt_last;  // counter at last tableau row
        logic meas_last; // counter at last measured row
    } status_t;

    function automatic logic [TRIT_W-1:0] add3(input logic [TRIT_W-1:0] a,
                                              input logic [TRIT_W-1:0] b);
        logic [TRIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 3'd3) begin
            s = s - 3'd3;
        end
        return s[TRIT_W-1:0];
    endfunction

    function automatic logic [TRIT_W-1:0] neg3(input logic [TRIT_W-1:0] a);
        logic [TRIT_W-1:0] r;
        r = (a == 2'd0) ? 2'd0 : 2'd3 - a;
        return r;
    endfunction

    function automatic logic [TRIT_W-1:0] sub3(input logic [TRIT_W-1:0] a,
                                              input logic [TRIT_W-1:0] b);
        return add3(a, neg3(b));
    endfunction

    function automatic logic [TRIT_W-1:0] mul3(input logic [TRIT_W-1:0] a,
                                              input logic [TRIT_W-1:0] b);
        logic [2*TRIT_W-1:0] p;
        logic [TRIT_W-1:0]   r;
        p = a * b;
        // products of trits: 0, 1, 2 or 4
        if (p == 4'd4) begin
            r = 2'd1;
        end
        else if (p == 4'd3) begin
            r = 2'd0;
        end
        else begin
            r = p[TRIT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/qtge_ctrl.sv =====
// Sequencer for the qutrit tableau gate engine: decodes each item and steps
// the datapath through row sweeps, accesses and result transfers. Uses qtge_pkg.
module qtge_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  qtge_pkg::status_t status,
    output qtge_pkg::cmd_t    cmd
);
    import qtge_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GATE,
        ST_EMIT,
        ST_MEAS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    assign in_ready = in_ready_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.cnt_clr = 1'b1;
                if (status.bad) begin
                    state_next = ST_EMIT;
                end
                else begin
                    unique case (status.op)
                        OP_HADAMARD, OP_PHASE, OP_CSUM:
                        begin
                            state_next = ST_GATE;
                        end
                        OP_WRITE_TRIT:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.wb     = 1'b1;
                            state_next = ST_EMIT;
                        end
                        OP_WRITE_PHASE:
                        begin
                            cmd.phase_wr = 1'b1;
                            state_next   = ST_EMIT;
                        end
                        OP_READ_TRIT:
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = ST_EMIT;
                        end
                        OP_READ_PHASE:
                        begin
                            state_next = ST_EMIT;
                        end
                        OP_MEASURE:
                        begin
                            state_next = ST_MEAS;
                        end
                    endcase
                end
            end
            ST_GATE:
            begin
                // one row read per cycle, each written back in the cycle after its read
                cmd.rd_en   = 1'b1;
                cmd.sweep   = 1'b1;
                cmd.wb      = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MEAS:
            begin
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    if (status.meas_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    // A rejected item never starts a sweep
    a_gate_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GATE) |-> !status.bad)
        else $error("gate sweep running on a rejected item");

    // Sweep ends on the last row
    a_gate_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GATE && status.cnt_last) |=> (state_reg == ST_EMIT))
        else $error("gate sweep did not stop at last row");

    // Final measured row returns to idle
    a_meas_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MEAS && cmd.emit && status.meas_last) |=> in_ready_reg)
        else $error("measure did not finish after last row");

endmodule

// ===== rtl/qtge_dp.sv =====
// Datapath of the qutrit tableau gate engine: item registers, row memory with
// valid bits, phase trits, row update logic, sweep counter and result register.
// Uses qtge_pkg; driven by qtge_ctrl.
module qtge_dp #(
    parameter int MAX_QUTRITS = qtge_pkg::MAX_QUTRITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [qtge_pkg::NQ_W-1:0]    cfg_data,
    input  logic [qtge_pkg::OP_W-1:0]    operation,
    input  logic [qtge_pkg::QI_W-1:0]    target,
    input  logic [qtge_pkg::QI_W-1:0]    control,
    input  logic [qtge_pkg::IDX_W-1:0]   row,
    input  logic [qtge_pkg::IDX_W-1:0]   column,
    input  logic [qtge_pkg::TRIT_W-1:0]  value,
    input  qtge_pkg::cmd_t               cmd,
    output qtge_pkg::status_t            status,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [qtge_pkg::TRIT_W-1:0]  result_value,
    output logic [qtge_pkg::IDX_W-1:0]   result_index,
    output logic                         last,
    output logic                         error
);
    import qtge_pkg::*;

    localparam int DIM    = 2 * MAX_QUTRITS;
    localparam int ROW_W  = $clog2(DIM);
    localparam int WORD_W = TRIT_W * DIM;

    // Configuration
    logic [NQ_W-1:0]   qutrit_count_reg;
    logic [CMP_W-1:0]  n_eff;
    logic [CMP_W-1:0]  dim;

    // Item registers
    op_t               op_reg;
    logic [QI_W-1:0]   tgt_reg;
    logic [QI_W-1:0]   ctl_reg;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  col_reg;
    logic [TRIT_W-1:0] val_reg;

    // Row memory and phases
    logic [WORD_W-1:0] tab_mem [DIM];
    logic [DIM-1:0]    row_vld_reg;
    logic [TRIT_W-1:0] phase_reg [DIM];
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_vld_reg;
    logic              wb_pend_reg;
    logic [ROW_W-1:0]  wb_addr_reg;
    logic [ROW_W-1:0]  cnt_reg;

    // Derived indexes
    logic [CMP_W-1:0]  tgt_ext;
    logic [CMP_W-1:0]  ctl_ext;
    logic [CMP_W-1:0]  row_ext;
    logic [CMP_W-1:0]  col_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  tx_ext;
    logic [CMP_W-1:0]  cx_ext;
    logic [ROW_W-1:0]  tz_idx;
    logic [ROW_W-1:0]  tx_idx;
    logic [ROW_W-1:0]  cz_idx;
    logic [ROW_W-1:0]  cx_idx;
    logic [ROW_W-1:0]  row_idx;
    logic [ROW_W-1:0]  col_idx;
    logic [ROW_W-1:0]  rd_addr;
    logic [ROW_W-1:0]  ph_addr;

    // Row update
    logic [WORD_W-1:0] row_cur;
    logic [WORD_W-1:0] row_new;
    logic [TRIT_W-1:0] zt;
    logic [TRIT_W-1:0] xt;
    logic [TRIT_W-1:0] zc;
    logic [TRIT_W-1:0] xc;
    logic [TRIT_W-1:0] nz;
    logic [TRIT_W-1:0] dph;
    logic [TRIT_W-1:0] ph_cur;
    logic [TRIT_W-1:0] ph_new;
    logic [TRIT_W-1:0] trit_rd;
    logic              is_gate;
    logic              bad;
    logic              row_oob;
    logic              col_oob;

    // Result register
    logic              out_valid_reg;
    logic [TRIT_W-1:0] res_value_reg;
    logic [IDX_W-1:0]  res_index_reg;
    logic              res_last_reg;
    logic              res_error_reg;
    logic [TRIT_W-1:0] res_value_next;
    logic [IDX_W-1:0]  res_index_next;
    logic              out_free;

    // Effective qutrit count, clamped to 1..MAX_QUTRITS
    always_comb
    begin
        priority if (qutrit_count_reg == '0) begin
            n_eff = CMP_W'(1);
        end
        else if (CMP_W'(qutrit_count_reg) > CMP_W'(MAX_QUTRITS)) begin
            n_eff = CMP_W'(MAX_QUTRITS);
        end
        else begin
            n_eff = CMP_W'(qutrit_count_reg);
        end
    end

    assign dim = n_eff << 1;

    // Column and row indexes
    assign tgt_ext = CMP_W'(tgt_reg);
    assign ctl_ext = CMP_W'(ctl_reg);
    assign row_ext = CMP_W'(row_reg);
    assign col_ext = CMP_W'(col_reg);
    assign cnt_ext = CMP_W'(cnt_reg);
    assign tx_ext  = tgt_ext + n_eff;
    assign cx_ext  = ctl_ext + n_eff;
    assign tz_idx  = tgt_ext[ROW_W-1:0];
    assign tx_idx  = tx_ext[ROW_W-1:0];
    assign cz_idx  = ctl_ext[ROW_W-1:0];
    assign cx_idx  = cx_ext[ROW_W-1:0];
    assign row_idx = row_ext[ROW_W-1:0];
    assign col_idx = col_ext[ROW_W-1:0];

    assign is_gate = (op_reg == OP_HADAMARD) || (op_reg == OP_PHASE) || (op_reg == OP_CSUM);
    assign row_oob = (row_ext >= dim);
    assign col_oob = (col_ext >= dim);

    // Range check of the latched item
    always_comb
    begin
        unique case (op_reg)
            OP_HADAMARD, OP_PHASE: bad = (tgt_ext >= n_eff);
            OP_CSUM:        bad = (tgt_ext >= n_eff) || (ctl_ext >= n_eff)
                                  || (tgt_reg == ctl_reg);
            OP_WRITE_TRIT:  bad = row_oob || col_oob || (val_reg == 2'd3);
            OP_WRITE_PHASE: bad = row_oob || (val_reg == 2'd3);
            OP_READ_TRIT:   bad = row_oob || col_oob;
            OP_READ_PHASE:  bad = row_oob;
            OP_MEASURE:     bad = 1'b0;
            default:        bad = 1'b0;
        endcase
    end

    assign rd_addr = cmd.sweep ? cnt_reg : row_idx;
    assign ph_addr = wb_pend_reg ? wb_addr_reg
                   : ((op_reg == OP_MEASURE) ? cnt_reg : row_idx);

    // Row never written reads as zero
    assign row_cur = rd_vld_reg ? rd_word_reg : '0;
    assign ph_cur  = phase_reg[ph_addr];
    assign zt      = row_cur[{tz_idx, 1'b0} +: TRIT_W];
    assign xt      = row_cur[{tx_idx, 1'b0} +: TRIT_W];
    assign zc      = row_cur[{cz_idx, 1'b0} +: TRIT_W];
    assign xc      = row_cur[{cx_idx, 1'b0} +: TRIT_W];
    assign trit_rd = row_cur[{col_idx, 1'b0} +: TRIT_W];
    assign nz      = neg3(xt);

    // Modified row and phase increment
    always_comb
    begin
        row_new = row_cur;
        dph     = '0;
        unique case (op_reg)
            OP_HADAMARD:
            begin
                row_new[{tz_idx, 1'b0} +: TRIT_W] = nz;
                row_new[{tx_idx, 1'b0} +: TRIT_W] = zt;
                dph = mul3(nz, zt);
            end
            OP_PHASE:
            begin
                row_new[{tz_idx, 1'b0} +: TRIT_W] = add3(zt, xt);
                dph = mul3(xt, zt);
            end
            OP_CSUM:
            begin
                row_new[{tz_idx, 1'b0} +: TRIT_W] = add3(zt, zc);
                row_new[{cx_idx, 1'b0} +: TRIT_W] = sub3(xc, xt);
                dph = mul3(zc, xt);
            end
            OP_WRITE_TRIT:
            begin
                row_new[{col_idx, 1'b0} +: TRIT_W] = val_reg;
            end
            default:
            begin
                row_new = row_cur;
            end
        endcase
    end

    assign ph_new = add3(ph_cur, dph);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            qutrit_count_reg <= NQ_RESET;
        end
        else if (cfg_we) begin
            qutrit_count_reg <= cfg_data;
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            op_reg  <= op_t'(operation);
            tgt_reg <= target;
            ctl_reg <= control;
            row_reg <= row;
            col_reg <= column;
            val_reg <= value;
        end
    end

    // Row memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wb_pend_reg) begin
            tab_mem[wb_addr_reg] <= row_new;
        end
        if (cmd.rd_en) begin
            rd_word_reg <= tab_mem[rd_addr];
            rd_vld_reg  <= row_vld_reg[rd_addr];
            wb_addr_reg <= rd_addr;
        end
    end

    // Valid bits, writeback flag, phases and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_vld_reg <= '0;
            wb_pend_reg <= 1'b0;
            cnt_reg     <= '0;
            for (int i = 0; i < DIM; i++) begin
                phase_reg[i] <= '0;
            end
        end
        else begin
            wb_pend_reg <= cmd.rd_en && cmd.wb;
            if (wb_pend_reg) begin
                row_vld_reg[wb_addr_reg] <= 1'b1;
                if (is_gate) begin
                    phase_reg[wb_addr_reg] <= ph_new;
                end
            end
            if (cmd.phase_wr) begin
                phase_reg[row_idx] <= val_reg;
            end
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Result fields
    always_comb
    begin
        res_value_next = '0;
        if (!bad) begin
            unique case (op_reg)
                OP_READ_TRIT:              res_value_next = trit_rd;
                OP_READ_PHASE, OP_MEASURE: res_value_next = ph_cur;
                default:                   res_value_next = '0;
            endcase
        end
        priority if (is_gate) begin
            res_index_next = '0;
        end
        else if (op_reg == OP_MEASURE) begin
            res_index_next = cnt_ext[IDX_W-1:0];
        end
        else begin
            res_index_next = row_reg;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            res_value_reg <= res_value_next;
            res_index_reg <= res_index_next;
            res_last_reg  <= (op_reg == OP_MEASURE) ? status.meas_last : 1'b1;
            res_error_reg <= bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_value_reg;
    assign result_index = res_index_reg;
    assign last         = res_last_reg;
    assign error        = res_error_reg;

    // Status to controller
    assign status.op        = op_reg;
    assign status.bad       = bad;
    assign status.out_free  = out_free;
    assign status.cnt_last  = (cnt_ext == dim - CMP_W'(1));
    assign status.meas_last = (cnt_ext == n_eff - CMP_W'(1));

    // Writeback never hits the row being read
    a_rw_sep: assert property (@(posedge clk) disable iff (!rst_n)
        (wb_pend_reg && cmd.rd_en) |-> (rd_addr != wb_addr_reg))
        else $error("row read and writeback collide");

    // Result only loaded when the register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result register overwritten");

    // Direct phase write never races a gate writeback
    a_phase_sep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.phase_wr |-> !wb_pend_reg)
        else $error("phase write during row writeback");

endmodule

// ===== rtl/qutrit_tableau_gate_engine.sv =====
// Qutrit tableau gate engine. Gates sweep one tableau row per cycle through the
// row memory read port, with writeback of each row in the cycle after its read.
// The next item is accepted once the last result sits in the output register.
// Reset: rows read as zero through per-row valid bits, phases zero, qutrit count 16;
// no clearing pass.
module qutrit_tableau_gate_engine #(
    parameter int MAX_QUTRITS = qtge_pkg::MAX_QUTRITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [qtge_pkg::NQ_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [qtge_pkg::OP_W-1:0]    operation,
    input  logic [qtge_pkg::QI_W-1:0]    target,
    input  logic [qtge_pkg::QI_W-1:0]    control,
    input  logic [qtge_pkg::IDX_W-1:0]   row,
    input  logic [qtge_pkg::IDX_W-1:0]   column,
    input  logic [qtge_pkg::TRIT_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [qtge_pkg::TRIT_W-1:0]  result_value,
    output logic [qtge_pkg::IDX_W-1:0]   result_index,
    output logic                         last,
    output logic                         error
);
    import qtge_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    qtge_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Tableau storage and update logic
    qtge_dp #(
        .MAX_QUTRITS (MAX_QUTRITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .target       (target),
        .control      (control),
        .row          (row),
        .column       (column),
        .value        (value),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .result_index (result_index),
        .last         (last),
        .error        (error)
    );

endmodule
